>>> design/depth_pixel_backprojection_core_macros.svh
// Assertion macros shared by the checker of the depth back-projection core.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpb assertion failed");

`endif

>>> design/dpb_pkg.sv
// Shared types, constants and widths of the depth pixel back-projection core.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dpb_pkg;

  localparam int unsigned MaxImageWidth  = 4096;
  localparam int unsigned MaxImageHeight = 4096;

  localparam int unsigned ColW = $clog2(MaxImageWidth);
  localparam int unsigned RowW = $clog2(MaxImageHeight);
  localparam int unsigned PosW = (ColW > RowW) ? ColW : RowW;

  // Register widths.
  localparam int unsigned WidthRegW = 13;
  localparam int unsigned CenterW   = 16;
  localparam int unsigned InvW      = 24;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CfgIdxW   = 3;

  // Field widths.
  localparam int unsigned RawW     = 24;
  localparam int unsigned MmW      = 16;
  localparam int unsigned ZW       = 26;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 96;

  // Arithmetic widths: magnitude of the centered position, its product with Z,
  // the two partial products with the 12-bit halves of 1/f, and their sum.
  localparam int unsigned InvHalfW = InvW / 2;
  localparam int unsigned MagW     = ((PosW + 4) > CenterW) ? (PosW + 4) : CenterW;
  localparam int unsigned AzW      = MagW + ZW;
  localparam int unsigned PartW    = AzW + InvHalfW;
  localparam int unsigned SumW     = AzW + InvW + 1;
  localparam int unsigned FracBits = 28;
  localparam int unsigned QW       = SumW - FracBits;

  localparam int unsigned MmToUm     = 1000;
  localparam int unsigned MinDepthUm = 100;

  // Register reset values.
  localparam logic                 FormatRst   = 1'b0;
  localparam logic [WidthRegW-1:0] WidthRst    = WidthRegW'(640);
  localparam logic [CenterW-1:0]   CenterXRst  = CenterW'(5120);
  localparam logic [CenterW-1:0]   CenterYRst  = CenterW'(3840);
  localparam logic [InvW-1:0]      InvFocalRst = InvW'(31957);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEPTH_FORMAT = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_CENTER_X     = 3'd2,
    REG_CENTER_Y     = 3'd3,
    REG_INV_FOCAL_X  = 3'd4,
    REG_INV_FOCAL_Y  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AZ,
    ST_PROD,
    ST_SUM,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // a request is taken this cycle
    logic az_en;     // multiply |d| by Z
    logic prod_en;   // multiply by the two halves of 1/f
    logic sum_en;    // combine partial products and round
    logic out_load;  // saturate and load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic keep;      // the offered pixel yields a point
    logic out_free;  // the output register can take a point this cycle
  } dp_status_t;

endpackage

`default_nettype wire

>>> design/dpb_ctrl.sv
// Controller of the depth back-projection core: sequences one kept pixel
// through the datapath stages. Depends on dpb_pkg.
`default_nettype none

module dpb_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire dpb_pkg::dp_status_t  status_i,
  output dpb_pkg::dp_cmd_t          cmd_o
);

  dpb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      dpb_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.keep) begin
          state_d = dpb_pkg::ST_AZ;
        end
      end
      dpb_pkg::ST_AZ: begin
        cmd_o.az_en = 1'b1;
        state_d     = dpb_pkg::ST_PROD;
      end
      dpb_pkg::ST_PROD: begin
        cmd_o.prod_en = 1'b1;
        state_d       = dpb_pkg::ST_SUM;
      end
      dpb_pkg::ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = dpb_pkg::ST_OUT;
      end
      dpb_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = dpb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dpb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/dpb_datapath.sv
// Datapath of the depth back-projection core: configuration registers, raster
// counters, depth conversion, two projection lanes and the output register.
// Depends on dpb_pkg.
`default_nettype none

module dpb_datapath (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [dpb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [dpb_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire  [dpb_pkg::RawW-1:0]       depth_raw_i,
  input  wire                            object_mask_i,
  input  wire                            frame_start_i,
  input  wire dpb_pkg::dp_cmd_t          cmd_i,
  output dpb_pkg::dp_status_t            status_o,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [dpb_pkg::CoordW-1:0]     point_x_o,
  output logic [dpb_pkg::CoordW-1:0]     point_y_o,
  output logic [dpb_pkg::ZW-1:0]         point_z_o
);

  localparam int unsigned Lanes = 2;

  // Configuration registers.
  logic                          fmt_q;
  logic [dpb_pkg::WidthRegW-1:0] width_q;
  logic [dpb_pkg::CenterW-1:0]   center_q [Lanes];
  logic [dpb_pkg::InvW-1:0]      inv_q    [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= dpb_pkg::FormatRst;
      width_q     <= dpb_pkg::WidthRst;
      center_q[0] <= dpb_pkg::CenterXRst;
      center_q[1] <= dpb_pkg::CenterYRst;
      inv_q[0]    <= dpb_pkg::InvFocalRst;
      inv_q[1]    <= dpb_pkg::InvFocalRst;
    end else if (cfg_we_i) begin
      unique case (dpb_pkg::reg_idx_e'(cfg_index_i))
        dpb_pkg::REG_DEPTH_FORMAT: fmt_q       <= cfg_wdata_i[0];
        dpb_pkg::REG_IMAGE_WIDTH:  width_q     <= cfg_wdata_i[dpb_pkg::WidthRegW-1:0];
        dpb_pkg::REG_CENTER_X:     center_q[0] <= cfg_wdata_i[dpb_pkg::CenterW-1:0];
        dpb_pkg::REG_CENTER_Y:     center_q[1] <= cfg_wdata_i[dpb_pkg::CenterW-1:0];
        dpb_pkg::REG_INV_FOCAL_X:  inv_q[0]    <= cfg_wdata_i[dpb_pkg::InvW-1:0];
        dpb_pkg::REG_INV_FOCAL_Y:  inv_q[1]    <= cfg_wdata_i[dpb_pkg::InvW-1:0];
        default: ;
      endcase
    end
  end

  // Raster counters. A width of zero or beyond the maximum acts as the maximum.
  logic [dpb_pkg::ColW-1:0] col_q, col_d, col_cur;
  logic [dpb_pkg::RowW-1:0] row_q, row_d, row_cur;
  logic [dpb_pkg::ColW:0]   width_eff, col_inc;
  logic [dpb_pkg::RowW:0]   row_inc;

  always_comb begin
    if (width_q == '0 || 32'(width_q) > dpb_pkg::MaxImageWidth) begin
      width_eff = (dpb_pkg::ColW + 1)'(dpb_pkg::MaxImageWidth);
    end else begin
      width_eff = (dpb_pkg::ColW + 1)'(width_q);
    end
    col_cur = frame_start_i ? '0 : col_q;
    if ((dpb_pkg::ColW + 1)'(col_cur) >= width_eff) begin
      col_cur = '0;
    end
    row_cur = frame_start_i ? '0 : row_q;
    col_inc = (dpb_pkg::ColW + 1)'(col_cur) + 1'b1;
    row_inc = (dpb_pkg::RowW + 1)'(row_cur) + 1'b1;
    col_d   = col_inc[dpb_pkg::ColW-1:0];
    row_d   = row_cur;
    if (col_inc >= width_eff) begin
      col_d = '0;
      if (32'(row_inc) >= dpb_pkg::MaxImageHeight) begin
        row_d = '0;
      end else begin
        row_d = row_inc[dpb_pkg::RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Depth in micrometres and the keep decision.
  logic [dpb_pkg::ZW-1:0] z_in;
  logic [dpb_pkg::ZW-1:0] z_q;

  always_comb begin
    if (fmt_q) begin
      z_in = dpb_pkg::ZW'(depth_raw_i);
    end else begin
      z_in = dpb_pkg::ZW'(depth_raw_i[dpb_pkg::MmW-1:0]) * dpb_pkg::ZW'(dpb_pkg::MmToUm);
    end
  end

  assign status_o.keep = object_mask_i && (32'(z_in) > dpb_pkg::MinDepthUm);

  // Projection lanes: lane 0 is X from the column, lane 1 is Y from the row.
  logic [dpb_pkg::PosW-1:0] pos_cur [Lanes];
  logic [dpb_pkg::MagW-1:0] pos16   [Lanes];
  logic [dpb_pkg::MagW-1:0] cent    [Lanes];
  logic [dpb_pkg::SumW-1:0] sum     [Lanes];
  logic [dpb_pkg::CoordW-1:0] sat   [Lanes];

  logic [dpb_pkg::MagW-1:0]  mag_q [Lanes];
  logic                      neg_q [Lanes];
  logic [dpb_pkg::AzW-1:0]   az_q  [Lanes];
  logic [dpb_pkg::PartW-1:0] hi_q  [Lanes];
  logic [dpb_pkg::PartW-1:0] lo_q  [Lanes];
  logic [dpb_pkg::QW-1:0]    q_q   [Lanes];

  assign pos_cur[0] = dpb_pkg::PosW'(col_cur);
  assign pos_cur[1] = dpb_pkg::PosW'(row_cur);

  localparam logic [dpb_pkg::QW-1:0] PosLimit = dpb_pkg::QW'(33'h0_7FFF_FFFF);
  localparam logic [dpb_pkg::QW-1:0] NegLimit = dpb_pkg::QW'(33'h0_8000_0000);

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      pos16[l] = dpb_pkg::MagW'({pos_cur[l], 4'b0000});
      cent[l]  = dpb_pkg::MagW'(center_q[l]);
      sum[l]   = (dpb_pkg::SumW'(hi_q[l]) << dpb_pkg::InvHalfW) + dpb_pkg::SumW'(lo_q[l])
               + (dpb_pkg::SumW'(1) << (dpb_pkg::FracBits - 1));
      if (!neg_q[l]) begin
        sat[l] = (q_q[l] > PosLimit) ? PosLimit[dpb_pkg::CoordW-1:0]
                                     : q_q[l][dpb_pkg::CoordW-1:0];
      end else if (q_q[l] > NegLimit) begin
        sat[l] = NegLimit[dpb_pkg::CoordW-1:0];
      end else begin
        sat[l] = ~q_q[l][dpb_pkg::CoordW-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      z_q <= z_in;
    end
    for (int l = 0; l < Lanes; l++) begin
      if (cmd_i.accept) begin
        neg_q[l] <= pos16[l] < cent[l];
        mag_q[l] <= (pos16[l] < cent[l]) ? (cent[l] - pos16[l]) : (pos16[l] - cent[l]);
      end
      if (cmd_i.az_en) begin
        az_q[l] <= dpb_pkg::AzW'(mag_q[l]) * dpb_pkg::AzW'(z_q);
      end
      if (cmd_i.prod_en) begin
        hi_q[l] <= dpb_pkg::PartW'(az_q[l])
                 * dpb_pkg::PartW'(inv_q[l][dpb_pkg::InvW-1:dpb_pkg::InvHalfW]);
        lo_q[l] <= dpb_pkg::PartW'(az_q[l])
                 * dpb_pkg::PartW'(inv_q[l][dpb_pkg::InvHalfW-1:0]);
      end
      if (cmd_i.sum_en) begin
        q_q[l] <= sum[l][dpb_pkg::SumW-1:dpb_pkg::FracBits];
      end
    end
  end

  // Output register.
  logic out_valid_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      point_x_o <= sat[0];
      point_y_o <= sat[1];
      point_z_o <= z_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> design/depth_pixel_backprojection_core.sv
// Top level of the depth pixel back-projection core.
// Depends on dpb_pkg, dpb_ctrl and dpb_datapath.
//
// Usage: depth pixels arrive in raster order on the slave stream. Each request
// carries depth_raw in tdata and the object mask and frame-start flags in
// tuser. The block keeps column and row counters, converts the depth to
// micrometres and, for a pixel inside the mask and deeper than 100 um, sends
// one back-projected point (X, Y, Z in micrometres) on the master stream.
// A pixel that yields no point is taken and the block stays ready for the
// next request. A pixel that yields a point runs through one |d|*Z multiply,
// one pair of partial products with 1/f and one rounding add, in the states
// AZ, PROD and SUM; in OUT the point is loaded into the output register once
// that is free, and the block returns to IDLE. No new request is taken until
// then; rejected pixels are taken one a cycle while the block is in IDLE.
// Reset restores the register defaults (millimetre format, width 640) and
// clears the counters and the output valid. When the receiver stalls, the
// output register holds its point; a further point waits in the datapath,
// and no new request is taken until it has moved into the output register.
// Configuration is written via cfg_we_i, cfg_index_i and cfg_wdata_i, by the
// user only while the block is idle (not enforced); unknown indexes ignored.
`default_nettype none

module depth_pixel_backprojection_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration write port.
  input  wire                              cfg_we_i,
  input  wire  [dpb_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [dpb_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Pixel stream.
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [dpb_pkg::InDataW-1:0]      s_axis_tdata,  // depth_raw[23:0]
  input  wire  [dpb_pkg::InUserW-1:0]      s_axis_tuser,  // object_mask, frame_start
  // Point stream.
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [dpb_pkg::OutDataW-1:0]     m_axis_tdata   // point_x, point_y, point_z, pad
);

  dpb_pkg::dp_cmd_t    cmd;
  dpb_pkg::dp_status_t status;

  logic [dpb_pkg::CoordW-1:0] point_x;
  logic [dpb_pkg::CoordW-1:0] point_y;
  logic [dpb_pkg::ZW-1:0]     point_z;

  dpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .depth_raw_i   (s_axis_tdata[dpb_pkg::RawW-1:0]),
    .object_mask_i (s_axis_tuser[0]),
    .frame_start_i (s_axis_tuser[1]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .point_z_o     (point_z)
  );

  // Pack the point, X in the lowest bits, and pad to whole bytes.
  assign m_axis_tdata = {
    (dpb_pkg::OutDataW - 2 * dpb_pkg::CoordW - dpb_pkg::ZW)'(0),
    point_z, point_y, point_x
  };

endmodule

`default_nettype wire

>>> design/dpb_checker.sv
// Port-level checker of the depth back-projection core and its bind.
// Depends on dpb_pkg and depth_pixel_backprojection_core_macros.svh.
`default_nettype none
`include "depth_pixel_backprojection_core_macros.svh"

module dpb_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [dpb_pkg::OutDataW-1:0]  m_axis_tdata
);

  // A stalled point stays offered and unchanged.
  `DPB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `DPB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // Every point sent has a depth above the minimum.
  `DPB_ASSERT_IMPL(a_min_depth, clk_i, rst_ni, m_axis_tvalid, 32'(m_axis_tdata[89:64]) > dpb_pkg::MinDepthUm)
  // A fresh point only appears after the input side was busy working on it.
  `DPB_ASSERT_IMPL(a_busy_before_out, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind depth_pixel_backprojection_core dpb_checker u_dpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
